// File: hw/rtl/pqt_pkg.sv
// ----------------------------------------------------------------------------
// pqt_pkg
// Shared constants for the point-in-quadrilateral crossing test.
// ----------------------------------------------------------------------------
package pqt_pkg;

  // default coordinate width, Q12.4 at 16 bits
  localparam int COORD_BITS_DEF = 16;

  // corners of the quadrilateral, and so also edges and cells in the chain
  localparam int NUM_VERTS = 4;

  // register stages inside one edge cell
  localparam int CELL_STAGES = 2;

endpackage

// File: hw/rtl/point_in_quad_test_core.sv
// ----------------------------------------------------------------------------
// point_in_quad_test_core
// Even-odd point-in-quadrilateral test as a chain of edge cells, one per edge.
// Each of the four cells holds 2 register stages.
// Throughput: one word per cycle while out_stall is low; each stage holds its word only while the
// next one is full and stalled, so bubbles are squeezed out.
// Reset: synchronous rst clears all stage valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module point_in_quad_test_core #(
  parameter int COORD_BITS = pqt_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] vertex_a_x,
  input  logic signed [COORD_BITS-1:0] vertex_a_y,
  input  logic signed [COORD_BITS-1:0] vertex_b_x,
  input  logic signed [COORD_BITS-1:0] vertex_b_y,
  input  logic signed [COORD_BITS-1:0] vertex_c_x,
  input  logic signed [COORD_BITS-1:0] vertex_c_y,
  input  logic signed [COORD_BITS-1:0] vertex_d_x,
  input  logic signed [COORD_BITS-1:0] vertex_d_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         inside_res
);

  localparam int NV = pqt_pkg::NUM_VERTS;

  logic                         ch_valid [NV+1];
  logic                         ch_ready [NV+1];
  logic signed [COORD_BITS-1:0] ch_pt_x  [NV+1];
  logic signed [COORD_BITS-1:0] ch_pt_y  [NV+1];
  logic signed [COORD_BITS-1:0] ch_vx    [NV+1][NV];
  logic signed [COORD_BITS-1:0] ch_vy    [NV+1][NV];
  logic                         ch_par   [NV+1];

  // word enters the chain with even parity
  always_comb begin
    ch_valid[0] = in_valid;
    ch_pt_x[0]  = point_x;
    ch_pt_y[0]  = point_y;
    ch_vx[0][0] = vertex_a_x;
    ch_vy[0][0] = vertex_a_y;
    ch_vx[0][1] = vertex_b_x;
    ch_vy[0][1] = vertex_b_y;
    ch_vx[0][2] = vertex_c_x;
    ch_vy[0][2] = vertex_c_y;
    ch_vx[0][3] = vertex_d_x;
    ch_vy[0][3] = vertex_d_y;
    ch_par[0]   = 1'b0;
  end

  for (genvar k = 0; k < NV; k++) begin : g_cell
    pqt_edge_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (ch_valid[k]),
      .up_ready (ch_ready[k]),
      .pt_x_in  (ch_pt_x[k]),
      .pt_y_in  (ch_pt_y[k]),
      .vx_in    (ch_vx[k]),
      .vy_in    (ch_vy[k]),
      .par_in   (ch_par[k]),
      .dn_valid (ch_valid[k+1]),
      .dn_ready (ch_ready[k+1]),
      .pt_x_out (ch_pt_x[k+1]),
      .pt_y_out (ch_pt_y[k+1]),
      .vx_out   (ch_vx[k+1]),
      .vy_out   (ch_vy[k+1]),
      .par_out  (ch_par[k+1])
    );
  end

  assign in_stall     = !ch_ready[0];
  assign ch_ready[NV] = !out_stall;
  assign out_valid    = ch_valid[NV];
  assign inside_res   = ch_par[NV];

endmodule

// File: hw/rtl/pqt_edge_cell.sv
// ----------------------------------------------------------------------------
// pqt_edge_cell
// One edge of the even-odd crossing test. Tests the edge from corner 0 back
// to the last corner, folds the crossing into the parity bit and hands the
// word on with the corners rotated by one, so that every cell is the same.
// ----------------------------------------------------------------------------
module pqt_edge_cell #(
  parameter int COORD_BITS = pqt_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [COORD_BITS-1:0] pt_x_in,
  input  logic signed [COORD_BITS-1:0] pt_y_in,
  input  logic signed [COORD_BITS-1:0] vx_in [pqt_pkg::NUM_VERTS],
  input  logic signed [COORD_BITS-1:0] vy_in [pqt_pkg::NUM_VERTS],
  input  logic                         par_in,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [COORD_BITS-1:0] pt_x_out,
  output logic signed [COORD_BITS-1:0] pt_y_out,
  output logic signed [COORD_BITS-1:0] vx_out [pqt_pkg::NUM_VERTS],
  output logic signed [COORD_BITS-1:0] vy_out [pqt_pkg::NUM_VERTS],
  output logic                         par_out
);

  localparam int NV = pqt_pkg::NUM_VERTS;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  // differences and straddle test on the incoming word
  logic signed [DW-1:0] dx_pt;
  logic signed [DW-1:0] dx_edge;
  logic signed [DW-1:0] dy_edge;
  logic signed [DW-1:0] dy_pt;
  logic signed [PW-1:0] lhs_prod;
  logic signed [PW-1:0] rhs_prod;
  logic                 straddle;

  // stage 1: products
  logic                         s1_valid;
  logic                         s1_ready;
  logic signed [PW-1:0]         s1_lhs;
  logic signed [PW-1:0]         s1_rhs;
  logic                         s1_dy_pos;
  logic                         s1_cross;
  logic                         s1_par;
  logic signed [COORD_BITS-1:0] s1_pt_x;
  logic signed [COORD_BITS-1:0] s1_pt_y;
  logic signed [COORD_BITS-1:0] s1_vx [NV];
  logic signed [COORD_BITS-1:0] s1_vy [NV];

  // stage 2: updated parity
  logic                         s2_valid;
  logic                         s2_ready;
  logic                         s2_par;
  logic signed [COORD_BITS-1:0] s2_pt_x;
  logic signed [COORD_BITS-1:0] s2_pt_y;
  logic signed [COORD_BITS-1:0] s2_vx [NV];
  logic signed [COORD_BITS-1:0] s2_vy [NV];

  logic left;

  always_comb begin
    dx_pt    = DW'(pt_x_in) - DW'(vx_in[0]);
    dx_edge  = DW'(vx_in[NV-1]) - DW'(vx_in[0]);
    dy_edge  = DW'(vy_in[NV-1]) - DW'(vy_in[0]);
    dy_pt    = DW'(pt_y_in) - DW'(vy_in[0]);
    lhs_prod = PW'(dx_pt) * PW'(dy_edge);
    rhs_prod = PW'(dx_edge) * PW'(dy_pt);
    straddle = (vy_in[0] > pt_y_in) != (vy_in[NV-1] > pt_y_in);
  end

  assign s2_ready = !s2_valid || dn_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign up_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_lhs    <= lhs_prod;
      s1_rhs    <= rhs_prod;
      s1_dy_pos <= !dy_edge[DW-1];
      s1_cross  <= straddle;
      s1_par    <= par_in;
      s1_pt_x   <= pt_x_in;
      s1_pt_y   <= pt_y_in;
      s1_vx     <= vx_in;
      s1_vy     <= vy_in;
    end
  end

  // comparison sense flips with the sign of the edge's dy
  assign left = s1_dy_pos ? (s1_lhs < s1_rhs) : (s1_rhs < s1_lhs);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_par  <= s1_par ^ (s1_cross && left);
      s2_pt_x <= s1_pt_x;
      s2_pt_y <= s1_pt_y;
      s2_vx   <= s1_vx;
      s2_vy   <= s1_vy;
    end
  end

  // rotate so the next cell sees the following edge
  always_comb begin
    for (int n = 0; n < NV - 1; n++) begin
      vx_out[n] = s2_vx[n+1];
      vy_out[n] = s2_vy[n+1];
    end
    vx_out[NV-1] = s2_vx[0];
    vy_out[NV-1] = s2_vy[0];
  end

  assign dn_valid = s2_valid;
  assign pt_x_out = s2_pt_x;
  assign pt_y_out = s2_pt_y;
  assign par_out  = s2_par;

  a_cross_dy_nonzero : assert property (@(posedge clk) disable iff (rst)
    up_valid && straddle |-> dy_edge != '0)
    else $error("straddling edge with zero dy");

  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    !up_ready |-> s1_valid && s2_valid && !dn_ready)
    else $error("cell stalls upstream with room to spare");

  a_held_word : assert property (@(posedge clk) disable iff (rst)
    s2_valid && !dn_ready |=> s2_valid && $stable(s2_par))
    else $error("held word lost or changed");

  a_parity_pass : assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready && !s1_cross |=> s2_par == $past(s1_par))
    else $error("parity toggled on an edge that does not straddle");

endmodule
